@@ hw/rtl/hse_pkg.sv @@
`default_nettype none

package hse_pkg;

   localparam int DEPTH      = 1024;
   localparam int DATA_WIDTH = 32;
   localparam int ADDR_W     = $clog2(DEPTH);
   localparam int CNT_W      = $clog2(DEPTH + 1);
   // Child indices of a node reach 2 * DEPTH, so they carry two bits more than an address.
   localparam int IDX_W      = ADDR_W + 2;

   // Item kinds on the request tuser bit.
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_READ = 1'b1;

   typedef logic signed [DATA_WIDTH-1:0] data_type;

   // Element store access from the host side, honored while the sorter is idle.
   typedef struct packed {
      logic              wr_en;
      logic              rd_en;
      logic [ADDR_W-1:0] addr;
      data_type          wr_data;
   } hse_host_req_type;

endpackage

`default_nettype wire

@@ hw/rtl/hse_sorter.sv @@
`default_nettype none

module hse_sorter (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire hse_pkg::hse_host_req_type host,
   input  wire logic                      start,
   input  wire logic [hse_pkg::CNT_W-1:0] count,
   output logic                           done,
   output hse_pkg::data_type              rd_data
);
   import hse_pkg::*;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_BUILD = 4'd1;
   localparam logic [3:0] S_GETV  = 4'd2;
   localparam logic [3:0] S_SD    = 4'd3;
   localparam logic [3:0] S_SDL   = 4'd4;
   localparam logic [3:0] S_SDR   = 4'd5;
   localparam logic [3:0] S_SDC   = 4'd6;
   localparam logic [3:0] S_EXT   = 4'd7;
   localparam logic [3:0] S_EXR0  = 4'd8;
   localparam logic [3:0] S_EXRE  = 4'd9;

   data_type mem [DEPTH];
   data_type rd_data_ff;

   logic [3:0]       state_ff, state_in;
   logic [CNT_W-1:0] limit_ff, limit_in;
   logic [CNT_W-1:0] p_ff, p_in;
   logic             extract_ff, extract_in;
   logic [ADDR_W-1:0] node_ff, node_in;
   logic [ADDR_W-1:0] bidx_ff, bidx_in;
   data_type         v_ff, v_in;
   data_type         lval_ff, lval_in;
   data_type         bval_ff, bval_in;

   logic              mem_we, mem_re;
   logic [ADDR_W-1:0] mem_wa, mem_ra;
   data_type          mem_wd;

   logic [IDX_W-1:0]  lch, rch, lim_x;
   logic              l_in_heap, r_in_heap;
   logic [CNT_W-1:0]  limit_m1, p_m1;
   data_type          cmp_a, cmp_b;
   logic              cmp_gt;

   assign lch       = {1'b0, node_ff, 1'b1};
   assign rch       = lch + IDX_W'(1);
   assign lim_x     = IDX_W'(limit_ff);
   assign l_in_heap = lch < lim_x;
   assign r_in_heap = rch < lim_x;
   assign limit_m1  = limit_ff - CNT_W'(1);
   assign p_m1      = p_ff - CNT_W'(1);

   // The single comparator: children against each other, then the winner against the
   // value being sifted.
   assign cmp_a  = (state_ff == S_SDR) ? rd_data_ff : bval_ff;
   assign cmp_b  = (state_ff == S_SDR) ? lval_ff : v_ff;
   assign cmp_gt = cmp_a > cmp_b;

   assign done    = (state_ff == S_EXT) && !(limit_ff > CNT_W'(1));
   assign rd_data = rd_data_ff;

   always_comb begin
      mem_we = 1'b0;
      mem_re = 1'b0;
      mem_wa = node_ff;
      mem_ra = node_ff;
      mem_wd = v_ff;
      case (state_ff)
         S_IDLE: begin
            mem_we = host.wr_en;
            mem_re = host.rd_en;
            mem_wa = host.addr;
            mem_ra = host.addr;
            mem_wd = host.wr_data;
         end
         S_BUILD: begin
            mem_re = (p_ff != '0);
            mem_ra = p_m1[ADDR_W-1:0];
         end
         S_SD: begin
            mem_re = l_in_heap;
            mem_ra = lch[ADDR_W-1:0];
            mem_we = !l_in_heap;
         end
         S_SDL: begin
            mem_re = r_in_heap;
            mem_ra = rch[ADDR_W-1:0];
         end
         S_SDC: begin
            mem_we = 1'b1;
            mem_wd = cmp_gt ? bval_ff : v_ff;
         end
         S_EXT: begin
            mem_re = (limit_ff > CNT_W'(1));
            mem_ra = '0;
         end
         S_EXR0: begin
            mem_re = 1'b1;
            mem_ra = limit_m1[ADDR_W-1:0];
         end
         S_EXRE: begin
            mem_we = 1'b1;
            mem_wa = limit_m1[ADDR_W-1:0];
            mem_wd = lval_ff;
         end
         default: begin
            mem_we = 1'b0;
            mem_re = 1'b0;
         end
      endcase
   end

   always_comb begin
      state_in   = state_ff;
      limit_in   = limit_ff;
      p_in       = p_ff;
      extract_in = extract_ff;
      node_in    = node_ff;
      bidx_in    = bidx_ff;
      v_in       = v_ff;
      lval_in    = lval_ff;
      bval_in    = bval_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               limit_in   = count;
               p_in       = count >> 1;
               extract_in = 1'b0;
               state_in   = S_BUILD;
            end
         end
         S_BUILD: begin
            if (p_ff == '0) begin
               extract_in = 1'b1;
               state_in   = S_EXT;
            end else begin
               p_in     = p_m1;
               node_in  = p_m1[ADDR_W-1:0];
               state_in = S_GETV;
            end
         end
         S_GETV: begin
            v_in     = rd_data_ff;
            state_in = S_SD;
         end
         S_SD: begin
            if (l_in_heap) begin
               state_in = S_SDL;
            end else begin
               state_in = extract_ff ? S_EXT : S_BUILD;
            end
         end
         S_SDL: begin
            lval_in = rd_data_ff;
            if (r_in_heap) begin
               state_in = S_SDR;
            end else begin
               bval_in  = rd_data_ff;
               bidx_in  = lch[ADDR_W-1:0];
               state_in = S_SDC;
            end
         end
         S_SDR: begin
            if (cmp_gt) begin
               bval_in = rd_data_ff;
               bidx_in = rch[ADDR_W-1:0];
            end else begin
               bval_in = lval_ff;
               bidx_in = lch[ADDR_W-1:0];
            end
            state_in = S_SDC;
         end
         S_SDC: begin
            if (cmp_gt) begin
               node_in  = bidx_ff;
               state_in = S_SD;
            end else begin
               state_in = extract_ff ? S_EXT : S_BUILD;
            end
         end
         S_EXT: begin
            state_in = (limit_ff > CNT_W'(1)) ? S_EXR0 : S_IDLE;
         end
         S_EXR0: begin
            lval_in  = rd_data_ff;
            state_in = S_EXRE;
         end
         S_EXRE: begin
            v_in     = rd_data_ff;
            limit_in = limit_m1;
            node_in  = '0;
            state_in = S_SD;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         limit_ff   <= '0;
         p_ff       <= '0;
         extract_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         limit_ff   <= limit_in;
         p_ff       <= p_in;
         extract_ff <= extract_in;
      end
   end

   always_ff @(posedge clock) begin
      node_ff <= node_in;
      bidx_ff <= bidx_in;
      v_ff    <= v_in;
      lval_ff <= lval_in;
      bval_ff <= bval_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_ra];
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/heap_sort_engine.sv @@
// Plain loads are taken back to back while the sequencer stays in ST_IDLE. A good read
// passes the store read, ST_RD and the pending register; a bad read or overflowing load
// only the pending register. Sorting N values holds off the request side for roughly
// N/2 + N sift passes, paced by the memory's single port pair and one shared comparator.
// Reset (synchronous, active high) clears the counters, the sorted flag and all handshake
// state; the element memory itself is not cleared.
`default_nettype none

module heap_sort_engine (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   input  wire logic [hse_pkg::DATA_WIDTH-1:0] req_tdata,  // [31:0] value
   input  wire logic                           req_tlast,  // last
   input  wire logic                           req_tuser,  // op
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   output logic [hse_pkg::DATA_WIDTH-1:0]      rsp_tdata,  // [31:0] sorted_value
   output logic                                rsp_tlast,  // final_res
   output logic                                rsp_tuser   // error
);
   import hse_pkg::*;

   // Front-end sequencer. Requests are taken only in ST_IDLE. Every result first lands in a
   // pending holding register (ST_RESP) and moves into the output register as soon as that
   // register is empty or being drained, so a stalled consumer never blocks plain loads.
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RD   = 2'd1;
   localparam logic [1:0] ST_RESP = 2'd2;
   localparam logic [1:0] ST_SORT = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] read_idx_ff, read_idx_in;
   logic             sorted_ff, sorted_in;
   logic             start_ff, start_in;
   logic             sort_after_ff, sort_after_in;

   data_type         pend_value_ff, pend_value_in;
   logic             pend_final_ff, pend_final_in;
   logic             pend_error_ff, pend_error_in;

   logic             rsp_valid_ff, rsp_valid_in;
   data_type         rsp_data_ff, rsp_data_in;
   logic             rsp_last_ff, rsp_last_in;
   logic             rsp_user_ff, rsp_user_in;

   logic             accept, is_load, overflow, rd_ok, out_free;
   logic [CNT_W-1:0] eff_count;
   hse_host_req_type host;
   logic             sort_done;
   data_type         mem_rd_data;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign is_load    = (req_tuser == OP_LOAD);

   // A load that follows a finished sort opens a new set, so it starts from an empty count.
   assign eff_count = sorted_ff ? '0 : count_ff;
   assign overflow  = (eff_count == CNT_W'(DEPTH));
   assign rd_ok     = sorted_ff && (read_idx_ff < count_ff);
   assign out_free  = !rsp_valid_ff || rsp_tready;

   // Loads that fit write straight into the element store; good reads fetch the next sorted value.
   always_comb begin
      host.wr_en   = accept && is_load && !overflow;
      host.rd_en   = accept && !is_load && rd_ok;
      host.addr    = is_load ? eff_count[ADDR_W-1:0] : read_idx_ff[ADDR_W-1:0];
      host.wr_data = req_tdata;
   end

   hse_sorter u_sorter (
      .clock   (clock),
      .reset   (reset),
      .host    (host),
      .start   (start_ff),
      .count   (count_ff),
      .done    (sort_done),
      .rd_data (mem_rd_data)
   );

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      read_idx_in   = read_idx_ff;
      sorted_in     = sorted_ff;
      start_in      = 1'b0;
      sort_after_in = sort_after_ff;
      pend_value_in = pend_value_ff;
      pend_final_in = pend_final_ff;
      pend_error_in = pend_error_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_user_in   = rsp_user_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (is_load) begin
                  if (sorted_ff) begin
                     sorted_in   = 1'b0;
                     read_idx_in = '0;
                     count_in    = '0;
                  end
                  if (!overflow) begin
                     count_in = eff_count + CNT_W'(1);
                     if (req_tlast) begin
                        start_in = 1'b1;
                        state_in = ST_SORT;
                     end
                  end else begin
                     // The beat is dropped, but a closing load still sorts what is held.
                     pend_value_in = '0;
                     pend_final_in = 1'b0;
                     pend_error_in = 1'b1;
                     sort_after_in = req_tlast;
                     state_in      = ST_RESP;
                  end
               end else if (rd_ok) begin
                  pend_final_in = (read_idx_ff + CNT_W'(1)) == count_ff;
                  pend_error_in = 1'b0;
                  read_idx_in   = read_idx_ff + CNT_W'(1);
                  state_in      = ST_RD;
               end else begin
                  pend_value_in = '0;
                  pend_final_in = 1'b0;
                  pend_error_in = 1'b1;
                  sort_after_in = 1'b0;
                  state_in      = ST_RESP;
               end
            end
         end
         ST_RD: begin
            pend_value_in = mem_rd_data;
            sort_after_in = 1'b0;
            state_in      = ST_RESP;
         end
         ST_RESP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = pend_value_ff;
               rsp_last_in  = pend_final_ff;
               rsp_user_in  = pend_error_ff;
               if (sort_after_ff) begin
                  sort_after_in = 1'b0;
                  start_in      = 1'b1;
                  state_in      = ST_SORT;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_SORT: begin
            if (sort_done) begin
               sorted_in   = 1'b1;
               read_idx_in = '0;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         read_idx_ff   <= '0;
         sorted_ff     <= 1'b0;
         start_ff      <= 1'b0;
         sort_after_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         read_idx_ff   <= read_idx_in;
         sorted_ff     <= sorted_in;
         start_ff      <= start_in;
         sort_after_ff <= sort_after_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_value_ff <= pend_value_in;
      pend_final_ff <= pend_final_in;
      pend_error_ff <= pend_error_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_user_ff   <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

`default_nettype wire
